// ===== rtl/core/sga_pkg.sv =====
// Shared types and constants of the sphere gradient accumulator.
package sga_pkg;

  localparam int ANGLE_FRAC_BITS_DEF = 30;
  localparam int ANGLE_W             = 32;
  localparam int ACC_W               = 64;
  localparam int QUO_FRAC            = 32;
  localparam int QUO_W               = 64;
  localparam int CNT_W               = $clog2(QUO_W);
  localparam int MUL_STEPS           = 7;
  localparam int CFG_IDX_W           = 1;

  localparam logic [CFG_IDX_W-1:0] REG_OBS_SIN_LAT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_OBS_COS_LAT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_FORM,
    ST_DIV,
    ST_TERM,
    ST_ADD,
    ST_EMIT
  } state_t;

  typedef enum logic [2:0] {
    MUL_S_SP   = 3'd0,
    MUL_C_CP   = 3'd1,
    MUL_S_CP   = 3'd2,
    MUL_C_SP   = 3'd3,
    MUL_CCP_CD = 3'd4,
    MUL_SCP_CD = 3'd5,
    MUL_CCP_SD = 3'd6
  } mul_op_t;

  typedef struct packed {
    logic    load;
    logic    mul_en;
    mul_op_t mul_op;
    logic    form;
    logic    div_step;
    logic    term;
    logic    add;
    logic    emit;
  } cmd_t;

  typedef struct packed {
    logic den_pos;
    logic last;
  } sts_t;

endpackage

// ===== rtl/core/sga_dp.sv =====
// Datapath: angle registers, shared multiplier, two-lane serial divider, accumulators.
module sga_dp #(
  parameter int ANGLE_FRAC_BITS = sga_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [sga_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [sga_pkg::ANGLE_W-1:0]          cfg_data,
  input  logic signed [sga_pkg::ANGLE_W-1:0]   src_sin_lat,
  input  logic signed [sga_pkg::ANGLE_W-1:0]   src_cos_lat,
  input  logic signed [sga_pkg::ANGLE_W-1:0]   sin_dlon,
  input  logic signed [sga_pkg::ANGLE_W-1:0]   cos_dlon,
  input  logic                                 last,
  input  sga_pkg::cmd_t                        cmd,
  output sga_pkg::sts_t                        sts,
  output logic signed [sga_pkg::ACC_W-1:0]     grad_lat,
  output logic signed [sga_pkg::ACC_W-1:0]     grad_lon,
  output logic                                 singular,
  output logic                                 saturated
);
  import sga_pkg::*;

  localparam int AW = ANGLE_FRAC_BITS + 2;
  localparam int PW = 2 * AW;
  localparam logic signed [AW-1:0] ONE = AW'(1) <<< ANGLE_FRAC_BITS;
  localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  function automatic logic signed [AW-1:0] clamp(input logic signed [ANGLE_W-1:0] v);
    logic signed [AW-1:0] r;
    if (v > ONE) begin
      r = ONE;
    end else if (v < -ONE) begin
      r = -ONE;
    end else begin
      r = AW'(v);
    end
    return r;
  endfunction

  // Turn an unsigned quotient and sign into a Q32.32 term; flag positive overflow.
  function automatic logic [ACC_W:0] to_term(input logic neg, input logic [QUO_W-1:0] q);
    logic [ACC_W:0] r;
    if (neg) begin
      r = {1'b0, (q[QUO_W-1] ? ACC_MIN : (~q + QUO_W'(1)))};
    end else if (q[QUO_W-1]) begin
      r = {1'b1, ACC_MAX};
    end else begin
      r = {1'b0, q};
    end
    return r;
  endfunction

  // Saturating add; top bit of the result marks saturation.
  function automatic logic [ACC_W:0] sat_add(input logic [ACC_W-1:0] a,
                                             input logic [ACC_W-1:0] b);
    logic [ACC_W:0] s;
    logic [ACC_W:0] r;
    s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
    if (s[ACC_W] != s[ACC_W-1]) begin
      r = {1'b1, (s[ACC_W] ? ACC_MIN : ACC_MAX)};
    end else begin
      r = {1'b0, s[ACC_W-1:0]};
    end
    return r;
  endfunction

  // Observer and source angles, clamped on capture
  logic signed [AW-1:0] obs_s, obs_c;
  logic signed [AW-1:0] sp, cp, sd, cd;
  logic                 last_r;

  // Product registers
  logic signed [AW-1:0] s_sp, c_cp, s_cp, c_sp, ccp_cd, scp_cd, ccp_sd;

  logic signed [AW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] prod, prod_sh;

  logic signed [AW:0]   den, nlat, nlon_x;
  logic [AW:0]          nlat_abs, nlon_abs;

  // Divider lanes
  logic [AW-1:0]        den_mag;
  logic                 neg_lat, neg_lon;
  logic [AW-1:0]        rem_lat, rem_lon;
  logic [QUO_W-1:0]     dq_lat, dq_lon;
  logic [AW:0]          rsh_lat, rsh_lon, dif_lat, dif_lon;
  logic                 ge_lat, ge_lon;

  logic [ACC_W:0]       term_lat_w, term_lon_w, sum_lat_w, sum_lon_w;
  logic [ACC_W-1:0]     term_lat, term_lon;
  logic [ACC_W-1:0]     acc_lat, acc_lon;
  logic                 term_sat, singular_seen, saturation_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      obs_s <= '0;
      obs_c <= ONE;  // clamp of 1.0 at the configured fraction width (Q2.30 by default)
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_OBS_SIN_LAT: obs_s <= clamp($signed(cfg_data));
        REG_OBS_COS_LAT: obs_c <= clamp($signed(cfg_data));
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sp     <= clamp(src_sin_lat);
      cp     <= clamp(src_cos_lat);
      sd     <= clamp(sin_dlon);
      cd     <= clamp(cos_dlon);
      last_r <= last;
    end
  end

  always_comb begin
    case (cmd.mul_op)
      MUL_S_SP: begin
        mul_a = obs_s;
        mul_b = sp;
      end
      MUL_C_CP: begin
        mul_a = obs_c;
        mul_b = cp;
      end
      MUL_S_CP: begin
        mul_a = obs_s;
        mul_b = cp;
      end
      MUL_C_SP: begin
        mul_a = obs_c;
        mul_b = sp;
      end
      MUL_CCP_CD: begin
        mul_a = c_cp;
        mul_b = cd;
      end
      MUL_SCP_CD: begin
        mul_a = s_cp;
        mul_b = cd;
      end
      MUL_CCP_SD: begin
        mul_a = c_cp;
        mul_b = sd;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Floor shift: arithmetic right shift rounds toward minus infinity
  assign prod    = mul_a * mul_b;
  assign prod_sh = prod >>> ANGLE_FRAC_BITS;

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      case (cmd.mul_op)
        MUL_S_SP:   s_sp   <= prod_sh[AW-1:0];
        MUL_C_CP:   c_cp   <= prod_sh[AW-1:0];
        MUL_S_CP:   s_cp   <= prod_sh[AW-1:0];
        MUL_C_SP:   c_sp   <= prod_sh[AW-1:0];
        MUL_CCP_CD: ccp_cd <= prod_sh[AW-1:0];
        MUL_SCP_CD: scp_cd <= prod_sh[AW-1:0];
        MUL_CCP_SD: ccp_sd <= prod_sh[AW-1:0];
        default: ;
      endcase
    end
  end

  assign den      = ONE - s_sp - ccp_cd;
  assign nlat     = scp_cd - c_sp;
  assign nlon_x   = ccp_sd;
  assign nlat_abs = nlat[AW] ? -nlat : nlat;
  assign nlon_abs = nlon_x[AW] ? -nlon_x : nlon_x;

  assign sts.den_pos = !den[AW] && (den != '0);
  assign sts.last    = last_r;

  // Restoring division, one quotient bit per lane per cycle
  assign rsh_lat = {rem_lat, dq_lat[QUO_W-1]};
  assign rsh_lon = {rem_lon, dq_lon[QUO_W-1]};
  assign dif_lat = rsh_lat - {1'b0, den_mag};
  assign dif_lon = rsh_lon - {1'b0, den_mag};
  assign ge_lat  = rsh_lat >= {1'b0, den_mag};
  assign ge_lon  = rsh_lon >= {1'b0, den_mag};

  always_ff @(posedge clk) begin
    if (cmd.form) begin
      den_mag <= den[AW-1:0];
      neg_lat <= nlat[AW];
      neg_lon <= nlon_x[AW];
      rem_lat <= '0;
      rem_lon <= '0;
      dq_lat  <= QUO_W'(nlat_abs[AW-1:0]) << QUO_FRAC;
      dq_lon  <= QUO_W'(nlon_abs[AW-1:0]) << QUO_FRAC;
    end else if (cmd.div_step) begin
      rem_lat <= ge_lat ? dif_lat[AW-1:0] : rsh_lat[AW-1:0];
      rem_lon <= ge_lon ? dif_lon[AW-1:0] : rsh_lon[AW-1:0];
      dq_lat  <= {dq_lat[QUO_W-2:0], ge_lat};
      dq_lon  <= {dq_lon[QUO_W-2:0], ge_lon};
    end
  end

  assign term_lat_w = to_term(neg_lat, dq_lat);
  assign term_lon_w = to_term(neg_lon, dq_lon);
  assign sum_lat_w  = sat_add(acc_lat, term_lat);
  assign sum_lon_w  = sat_add(acc_lon, term_lon);

  always_ff @(posedge clk) begin
    if (cmd.term) begin
      term_lat <= term_lat_w[ACC_W-1:0];
      term_lon <= term_lon_w[ACC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_lat         <= '0;
      acc_lon         <= '0;
      term_sat        <= 1'b0;
      singular_seen   <= 1'b0;
      saturation_seen <= 1'b0;
    end else if (cmd.emit) begin
      acc_lat         <= '0;
      acc_lon         <= '0;
      singular_seen   <= 1'b0;
      saturation_seen <= 1'b0;
    end else begin
      if (cmd.form && !sts.den_pos) begin
        singular_seen <= 1'b1;
      end
      if (cmd.term) begin
        term_sat <= term_lat_w[ACC_W] || term_lon_w[ACC_W];
      end
      if (cmd.add) begin
        acc_lat <= sum_lat_w[ACC_W-1:0];
        acc_lon <= sum_lon_w[ACC_W-1:0];
        if (term_sat || sum_lat_w[ACC_W] || sum_lon_w[ACC_W]) begin
          saturation_seen <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      grad_lat  <= acc_lat;
      grad_lon  <= acc_lon;
      singular  <= singular_seen;
      saturated <= saturation_seen;
    end
  end

endmodule

// ===== rtl/core/sga_ctrl.sv =====
// Controller: sequences multiply, divide and accumulate steps and owns the handshakes.
module sga_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  sga_pkg::sts_t  sts,
  output sga_pkg::cmd_t  cmd
);
  import sga_pkg::*;

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt;
  logic             out_free;
  logic             mul_last, div_last;

  assign out_free = !out_valid || !out_stall;
  assign mul_last = (cnt == CNT_W'(MUL_STEPS - 1));
  assign div_last = (cnt == CNT_W'(QUO_W - 1));

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid) state_next = ST_MUL;
      ST_MUL:  if (mul_last) state_next = ST_FORM;
      ST_FORM: begin
        if (sts.den_pos) begin
          state_next = ST_DIV;
        end else begin
          state_next = sts.last ? ST_EMIT : ST_IDLE;
        end
      end
      ST_DIV:  if (div_last) state_next = ST_TERM;
      ST_TERM: state_next = ST_ADD;
      ST_ADD:  state_next = sts.last ? ST_EMIT : ST_IDLE;
      ST_EMIT: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.mul_op = mul_op_t'(cnt[2:0]);
    in_stall   = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_MUL:  cmd.mul_en   = 1'b1;
      ST_FORM: cmd.form     = 1'b1;
      ST_DIV:  cmd.div_step = 1'b1;
      ST_TERM: cmd.term     = 1'b1;
      ST_ADD:  cmd.add      = 1'b1;
      ST_EMIT: cmd.emit     = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state_next != state) begin
        cnt <= '0;
      end else begin
        cnt <= cnt + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ===== rtl/core/sphere_gradient_accumulator.sv =====
// Top level of the sphere gradient accumulator: controller plus datapath.
//
// Sums the potential gradient at one observer point over a batch of sources.
// Set the observer latitude sine and cosine (signed Q2.30) through the write
// port before a batch; they hold across batches. Each input beat carries one
// source's latitude sine and cosine and the sine and cosine of the longitude
// difference. All angles are clamped to [-1, 1] on use. For each source the
// block forms denom = 1 - s*s' - c*c'*cos(dlon) and adds the latitude term
// (s*c'*cos(dlon) - c*s')/denom and the longitude term (c*c'*sin(dlon))/denom
// to saturating Q32.32 sums. A source whose denom is zero or negative
// (coincident points) adds nothing and raises the singular flag. The beat
// marked last makes one output beat with the sums, including its own term,
// and the flags, then clears the batch state.
//
// Sequence: a source runs through these steps before the next beat is taken:
// accept, 7 products on the single shared multiplier, forming denom and the
// numerators, the bit-serial divider (both quotients are found side by side,
// one bit per cycle, from the common denom), then saturating the quotients
// and adding. A singular source skips the divide, saturate and add steps. A
// last beat also loads the output register; if that register is still held
// by out_stall, hold until it frees. The input side stalls while a source is
// in work; a result waiting in the output register does not stop the next
// source.
module sphere_gradient_accumulator #(
  parameter int ANGLE_FRAC_BITS = sga_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // Configuration write port
  input  logic                                 cfg_write,
  input  logic [sga_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [sga_pkg::ANGLE_W-1:0]          cfg_data,
  // Source channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [sga_pkg::ANGLE_W-1:0]   src_sin_lat,
  input  logic signed [sga_pkg::ANGLE_W-1:0]   src_cos_lat,
  input  logic signed [sga_pkg::ANGLE_W-1:0]   sin_dlon,
  input  logic signed [sga_pkg::ANGLE_W-1:0]   cos_dlon,
  input  logic                                 last,
  // Result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [sga_pkg::ACC_W-1:0]     grad_lat,
  output logic signed [sga_pkg::ACC_W-1:0]     grad_lon,
  output logic                                 singular,
  output logic                                 saturated
);
  import sga_pkg::*;

  // Commands from the sequencer, status back from the datapath
  cmd_t cmd;
  sts_t sts;

  sga_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  sga_dp #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .src_sin_lat (src_sin_lat),
    .src_cos_lat (src_cos_lat),
    .sin_dlon    (sin_dlon),
    .cos_dlon    (cos_dlon),
    .last        (last),
    .cmd         (cmd),
    .sts         (sts),
    .grad_lat    (grad_lat),
    .grad_lon    (grad_lon),
    .singular    (singular),
    .saturated   (saturated)
  );

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the sphere gradient accumulator.
`timescale 1ns / 1ps

module testbench;
  import sga_pkg::*;

  // Scale and limits of the fixed-point formats
  localparam int FRAC = ANGLE_FRAC_BITS_DEF;
  localparam longint ONE = longint'(1) <<< FRAC;
  localparam longint SUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint SUM_MIN = 64'sh8000_0000_0000_0000;

  // Raw angle codes for the directed beats
  localparam logic [ANGLE_W-1:0] A_ONE = 32'h4000_0000;
  localparam logic [ANGLE_W-1:0] A_NEG = 32'hC000_0000;
  localparam logic [ANGLE_W-1:0] A_HI  = 32'h7FFF_FFFF;
  localparam logic [ANGLE_W-1:0] A_LO  = 32'h8000_0000;

  // Settle for longer than one source takes to pass through the block
  localparam int SETTLE      = 120;
  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int SQUEEZE_LEN = 1500;

  typedef struct {
    logic [ANGLE_W-1:0] sin_lat;
    logic [ANGLE_W-1:0] cos_lat;
    logic [ANGLE_W-1:0] sin_d;
    logic [ANGLE_W-1:0] cos_d;
    logic               last;
  } source_t;

  typedef struct {
    logic [ACC_W-1:0] lat;
    logic [ACC_W-1:0] lon;
    logic             sing;
    logic             sat;
  } gradient_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [ANGLE_W-1:0]   cfg_data  = '0;

  logic                      in_valid    = 1'b0;
  logic                      in_stall;
  logic signed [ANGLE_W-1:0] src_sin_lat = '0;
  logic signed [ANGLE_W-1:0] src_cos_lat = '0;
  logic signed [ANGLE_W-1:0] sin_dlon    = '0;
  logic signed [ANGLE_W-1:0] cos_dlon    = '0;
  logic                      last        = 1'b0;

  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [ACC_W-1:0] grad_lat;
  logic signed [ACC_W-1:0] grad_lon;
  logic                    singular;
  logic                    saturated;

  sphere_gradient_accumulator u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .src_sin_lat(src_sin_lat),
    .src_cos_lat(src_cos_lat),
    .sin_dlon   (sin_dlon),
    .cos_dlon   (cos_dlon),
    .last       (last),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .grad_lat   (grad_lat),
    .grad_lon   (grad_lon),
    .singular   (singular),
    .saturated  (saturated)
  );

  always #5 clk = ~clk;

  // Sources waiting to be offered, and gradients waiting to come out
  source_t   src_q[$];
  gradient_t grad_q[$];

  int n_queued = 0;  // beats handed to the driver
  int n_taken  = 0;  // beats accepted by the block
  int n_fail   = 0;
  int n_cycles = 0;

  // Traffic shaping: steady drops every random gap on both sides,
  // squeeze asks the receiver for one long hold-off
  logic steady       = 1'b0;
  logic squeeze_req  = 1'b0;
  logic squeeze_done = 1'b0;

  // Mirror of the observer registers and of the batch sums
  logic [ANGLE_W-1:0] obs_sin = '0;
  logic [ANGLE_W-1:0] obs_cos = A_ONE;
  longint             run_lat = 0;
  longint             run_lon = 0;
  logic               run_singular = 1'b0;
  logic               run_sat = 1'b0;

  // ---------------------------------------------------------------------------
  // Gradient predictor
  // ---------------------------------------------------------------------------

  // Sign-extend a raw angle and clamp it to [-1, 1]
  function automatic longint clamp_angle(logic [ANGLE_W-1:0] raw);
    longint v;
    v = longint'(signed'(raw));
    if (v > ONE) return ONE;
    if (v < -ONE) return -ONE;
    return v;
  endfunction

  // Exact product, then an arithmetic shift: rounds toward minus infinity
  function automatic longint qmul(longint a, longint b);
    return (a * b) >>> FRAC;
  endfunction

  // Q32.32 quotient, truncated toward zero; only a positive overflow flags
  function automatic longint quotient(longint num, longint den);
    logic [63:0] mag;
    logic [63:0] q;
    mag = (num < 0) ? -num : num;
    q = (mag << QUO_FRAC) / den;
    if (num < 0) return q[63] ? SUM_MIN : -longint'(q);
    if (q[63]) begin
      run_sat = 1'b1;
      return SUM_MAX;
    end
    return longint'(q);
  endfunction

  // Saturating add: a wrapped sum shows up as a move the wrong way
  function automatic longint sat_sum(longint a, longint b);
    longint s;
    s = a + b;
    if (b > 0 && s < a) begin
      run_sat = 1'b1;
      return SUM_MAX;
    end
    if (b < 0 && s > a) begin
      run_sat = 1'b1;
      return SUM_MIN;
    end
    return s;
  endfunction

  // Fold one accepted source into the batch; on last, queue the gradient
  function automatic void take_source(source_t b);
    longint s, c, sp, cp, sd, cd, ccp, den, nlat, nlon;
    gradient_t g;
    s   = clamp_angle(obs_sin);
    c   = clamp_angle(obs_cos);
    sp  = clamp_angle(b.sin_lat);
    cp  = clamp_angle(b.cos_lat);
    sd  = clamp_angle(b.sin_d);
    cd  = clamp_angle(b.cos_d);
    ccp = qmul(c, cp);
    den = ONE - qmul(s, sp) - qmul(ccp, cd);
    if (den <= 0) begin
      // coincident points: skip both terms
      run_singular = 1'b1;
    end else begin
      nlat = qmul(qmul(s, cp), cd) - qmul(c, sp);
      nlon = qmul(ccp, sd);
      run_lat = sat_sum(run_lat, quotient(nlat, den));
      run_lon = sat_sum(run_lon, quotient(nlon, den));
    end
    if (b.last) begin
      g.lat  = run_lat;
      g.lon  = run_lon;
      g.sing = run_singular;
      g.sat  = run_sat;
      grad_q.push_back(g);
      run_lat = 0;
      run_lon = 0;
      run_singular = 1'b0;
      run_sat = 1'b0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Mostly in-range angles, some exact extremes, some raw 32-bit noise that
  // exercises the clamp and every bit of the field
  function automatic logic [ANGLE_W-1:0] pick_angle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 32'($urandom_range(0, 32'h8000_0000)) - A_ONE;
    if (r < 90) begin
      case ($urandom_range(0, 4))
        0: return A_ONE;
        1: return A_NEG;
        2: return A_ONE - 1;
        3: return A_NEG + 1;
        default: return '0;
      endcase
    end
    return $urandom();
  endfunction

  // Gap after each sender beat: mostly none, some short, a few long enough to
  // land anywhere in a source's processing
  function automatic int next_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 4);
    return $urandom_range(5, 120);
  endfunction

  task automatic add_source(logic [ANGLE_W-1:0] sp, logic [ANGLE_W-1:0] cp,
                            logic [ANGLE_W-1:0] sd, logic [ANGLE_W-1:0] cd,
                            logic lst);
    source_t b;
    b.sin_lat = sp;
    b.cos_lat = cp;
    b.sin_d   = sd;
    b.cos_d   = cd;
    b.last    = lst;
    src_q.push_back(b);
    n_queued++;
  endtask

  // One batch of random sources. Some sit close to the observer so that the
  // denominator gets small and the sums head for saturation.
  task automatic random_batch(output int len);
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < 15)
        add_source(obs_sin + 32'($urandom_range(0, 64)) - 32'd32,
                   obs_cos + 32'($urandom_range(0, 64)) - 32'd32,
                   32'($urandom_range(0, 4096)) - 32'd2048,
                   A_ONE - 32'($urandom_range(0, 16)),
                   i == len - 1);
      else
        add_source(pick_angle(), pick_angle(), pick_angle(), pick_angle(), i == len - 1);
    end
  endtask

  task automatic random_phase(int n);
    int added;
    int len;
    added = 0;
    while (added < n) begin
      random_batch(len);
      added += len;
    end
  endtask

  // Idle point: every beat taken, every gradient back, then let the block
  // finish whatever source it still has in hand
  task automatic drain();
    while (n_taken != n_queued || grad_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [ANGLE_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic set_observer(logic [ANGLE_W-1:0] s, logic [ANGLE_W-1:0] c);
    drain();
    write_reg(REG_OBS_SIN_LAT, s);
    write_reg(REG_OBS_COS_LAT, c);
  endtask

  task automatic report(string what, logic [63:0] want, logic [63:0] got);
    $display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
    n_fail++;
  endtask

  // ---------------------------------------------------------------------------
  // Sender: offer queued sources, hold the payload while stalled
  // ---------------------------------------------------------------------------
  int      src_gap = 0;
  source_t beat_out;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      src_gap  <= 0;
    end else if (!in_valid || !in_stall) begin
      // slot is free: either nothing was offered or the beat was just taken
      if (src_gap > 0) begin
        in_valid <= 1'b0;
        src_gap  <= src_gap - 1;
      end else if (src_q.size() > 0) begin
        beat_out    = src_q.pop_front();
        in_valid    <= 1'b1;
        src_sin_lat <= beat_out.sin_lat;
        src_cos_lat <= beat_out.cos_lat;
        sin_dlon    <= beat_out.sin_d;
        cos_dlon    <= beat_out.cos_d;
        last        <= beat_out.last;
        src_gap     <= next_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  int hold_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (squeeze_req && !squeeze_done) begin
      // hold off long enough for the block to back up into its input
      out_stall    <= 1'b1;
      hold_left    <= SQUEEZE_LEN;
      squeeze_done <= 1'b1;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!steady && $urandom_range(0, 99) < 25) begin
      out_stall <= 1'b1;
      hold_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 90) : $urandom_range(0, 3);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: track register writes, predict on every accepted source and
  // check every accepted gradient against the oldest prediction
  // ---------------------------------------------------------------------------
  source_t   beat_in;
  gradient_t want;

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_write) begin
        if (cfg_index == REG_OBS_SIN_LAT)
          obs_sin = cfg_data;
        else if (cfg_index == REG_OBS_COS_LAT)
          obs_cos = cfg_data;
      end
      if (in_valid && !in_stall) begin
        beat_in.sin_lat = src_sin_lat;
        beat_in.cos_lat = src_cos_lat;
        beat_in.sin_d   = sin_dlon;
        beat_in.cos_d   = cos_dlon;
        beat_in.last    = last;
        take_source(beat_in);
        n_taken++;
      end
      if (out_valid && !out_stall) begin
        if (grad_q.size() == 0) begin
          $display("%0t: unexpected gradient: lat %h lon %h singular %b saturated %b",
                   $time, grad_lat, grad_lon, singular, saturated);
          n_fail++;
        end else begin
          want = grad_q.pop_front();
          if (grad_lat !== want.lat) report("grad_lat", want.lat, grad_lat);
          if (grad_lon !== want.lon) report("grad_lon", want.lon, grad_lon);
          if (singular !== want.sing) report("singular", 64'(want.sing), 64'(singular));
          if (saturated !== want.sat) report("saturated", 64'(want.sat), 64'(saturated));
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles == CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Observer at reset: on the equator, sin 0 and cos 1.
    add_source('0, '0, '0, '0, 1'b1);                // every field zero
    add_source('0, A_ONE, '0, A_ONE, 1'b1);          // source on the observer
    add_source(A_HI, '0, A_LO, A_LO, 1'b0);          // raw extremes, clamped
    add_source(A_LO, A_LO, A_HI, A_HI, 1'b1);
    // Denominator of one LSB: each longitude term is 2^62, so the sum overflows
    add_source('0, A_ONE, A_ONE, A_ONE - 1, 1'b0);
    add_source('0, A_ONE, A_ONE, A_ONE - 1, 1'b0);
    add_source('0, A_ONE, A_ONE, A_ONE - 1, 1'b1);
    // Same towards the negative limit
    add_source('0, A_ONE, A_NEG, A_ONE - 1, 1'b0);
    add_source('0, A_ONE, A_NEG, A_ONE - 1, 1'b0);
    add_source('0, A_ONE, A_NEG, A_ONE - 1, 1'b1);
    // A coincident source inside an otherwise normal batch
    add_source('0, '0, '0, '0, 1'b0);
    add_source('0, A_ONE, '0, A_ONE, 1'b1);

    // Observer at the pole with a reversed cosine, written as raw extremes
    set_observer(A_HI, A_LO);
    add_source(A_ONE, A_ONE, '0, A_ONE, 1'b1);       // largest positive numerator
    add_source(A_NEG, A_NEG, '0, A_ONE, 1'b1);       // largest negative numerator
    add_source(A_ONE, '0, A_ONE, '0, 1'b1);          // zero denominator
    add_source('0, A_ONE, A_NEG, '0, 1'b1);

    // Observer at the far pole, lowest register value
    set_observer(A_NEG, '0);
    add_source(A_ONE, A_ONE, A_ONE, A_ONE, 1'b0);
    add_source(A_NEG, '0, '0, '0, 1'b1);
    add_source($urandom(), $urandom(), $urandom(), $urandom(), 1'b1);

    // Random phases, each with its own observer
    set_observer(32'($urandom_range(0, 32'h8000_0000)) - A_ONE,
                 32'($urandom_range(0, 32'h4000_0000)));
    random_phase(130);

    set_observer(A_ONE, '0);
    random_phase(130);

    set_observer(pick_angle(), pick_angle());
    steady <= 1'b1;
    random_phase(130);

    // Back-pressure: one-source batches offered flat out while the
    // receiver holds off for a long stretch
    set_observer(pick_angle(), pick_angle());
    squeeze_req <= 1'b1;
    for (int i = 0; i < 30; i++)
      add_source(pick_angle(), pick_angle(), pick_angle(), pick_angle(), 1'b1);
    drain();
    steady <= 1'b0;

    for (int p = 0; p < 3; p++) begin
      set_observer(pick_angle(), pick_angle());
      random_phase(130);
    end

    drain();
    if (n_fail == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

endmodule
